// ----- design/bpdr_pkg.sv -----
// ----------------------------------------------------------------------------
// bpdr_pkg
// Shared types and constants for the byte packet deframer with resync.
// ----------------------------------------------------------------------------
`default_nettype none

package bpdr_pkg;

	localparam logic [7:0] START_DELTA   = 8'h41;
	localparam logic [7:0] START_BRICK   = 8'h51;
	localparam logic [7:0] START_RESPAWN = 8'h52;
	localparam logic [7:0] SLOT_LIMIT    = 8'd4;

	localparam logic [2:0] LEN_SHORT    = 3'd4;
	localparam logic [2:0] LEN_EXTENDED = 3'd5;
	localparam logic [2:0] LEN_LONG     = 3'd6;

	localparam int OUT_BYTES = 6;

	// request kinds
	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_COUNT = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_NONE  = 2'd0;
	localparam logic [1:0] STATUS_FRAME = 2'd1;
	localparam logic [1:0] STATUS_COUNT = 2'd2;

	// configuration register indexes
	localparam logic CFG_OWN_SLOT = 1'b0;
	localparam logic CFG_CAPACITY = 1'b1;

	typedef enum logic [1:0] {
		KIND_COUNT_READ,
		KIND_START_SHORT,
		KIND_START_LONG,
		KIND_PLAIN
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic [2:0]                 length;
		logic [OUT_BYTES-1:0][7:0]  bytes;
		logic [31:0]                total;
	} result_t;

endpackage

`default_nettype wire

// ----- design/byte_packet_deframer_resync.sv -----
// ----------------------------------------------------------------------------
// byte_packet_deframer_resync
// Deframes start-coded packets from a received byte stream, resynchronises
// on frames for other slots and reports the resync count on request.
//
//   channel   handshake           payload
//   -------   -----------------   -----------------------------------------
//   request   push / full         req_type, rx_byte
//   result    pop / empty         status, frame_length, frame_byte0..5,
//                                 resync_total
//   config    cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request in and one result out per cycle when both sides flow.
// A request reaches the result ports through the classifier queue: the
// collector works on the head of the classifier queue and registers its
// result into the result queue.
// Both two-entry queues absorb a stalled consumer without dropping rate.
// Reset empties both queues, idles the collector and clears the count.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_packet_deframer_resync #(
	parameter int FRAME_BYTES = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        req_type,
	input  wire logic [7:0]  rx_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       status,
	output logic [2:0]       frame_length,
	output logic [7:0]       frame_byte0,
	output logic [7:0]       frame_byte1,
	output logic [7:0]       frame_byte2,
	output logic [7:0]       frame_byte3,
	output logic [7:0]       frame_byte4,
	output logic [7:0]       frame_byte5,
	output logic [31:0]      resync_total,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import bpdr_pkg::*;

	logic [7:0] own_slot_q;
	logic [2:0] capacity_q;
	logic       item_valid;
	item_t      item;
	logic       take;
	result_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_slot_q <= 8'd0;
			capacity_q <= 3'd6;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OWN_SLOT: own_slot_q <= cfg_data;
				CFG_CAPACITY: capacity_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	bpdr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.rx_byte    (rx_byte),
		.item_valid (item_valid),
		.item       (item),
		.take       (take)
	);

	bpdr_back #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.own_slot   (own_slot_q),
		.capacity   (capacity_q),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign status       = res.status;
	assign frame_length = res.length;
	assign frame_byte0  = res.bytes[0];
	assign frame_byte1  = res.bytes[1];
	assign frame_byte2  = res.bytes[2];
	assign frame_byte3  = res.bytes[3];
	assign frame_byte4  = res.bytes[4];
	assign frame_byte5  = res.bytes[5];
	assign resync_total = res.total;

	// a result without a completed frame carries no length
	a_len_only_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != STATUS_FRAME) |-> (frame_length == 3'd0))
		else $error("frame length set on a non-frame result");

	// only the three frame forms can be copied out
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (frame_length == 3'd0 || frame_length == LEN_SHORT ||
		            frame_length == LEN_EXTENDED || frame_length == LEN_LONG))
		else $error("illegal frame length");

	// a nothing-complete result is all zero
	a_none_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == STATUS_NONE) |-> (resync_total == 32'd0 &&
		                                      frame_byte0 == 8'd0))
		else $error("idle result carries data");

	// an untaken head result holds while the consumer stalls
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(resync_total)))
		else $error("waiting result changed");

endmodule

`default_nettype wire

// ----- design/bpdr_front.sv -----
// ----------------------------------------------------------------------------
// bpdr_front
// Accepts requests, classifies each received byte by its start code and
// holds the classified beats in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdr_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic            req_type,
	input  wire logic [7:0]      rx_byte,
	output logic                 item_valid,
	output bpdr_pkg::item_t      item,
	input  wire logic            take
);
	import bpdr_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      item_in;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		item_in.data = rx_byte;
		if (req_type == REQ_COUNT) begin
			item_in.kind = KIND_COUNT_READ;
		end else if (rx_byte == START_DELTA || rx_byte == START_BRICK) begin
			item_in.kind = KIND_START_SHORT;
		end else if (rx_byte == START_RESPAWN) begin
			item_in.kind = KIND_START_LONG;
		end else begin
			item_in.kind = KIND_PLAIN;
		end
	end

	assign full       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = take && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

`default_nettype wire

// ----- design/bpdr_back.sv -----
// ----------------------------------------------------------------------------
// bpdr_back
// Frame collector: keeps the deframer state, the byte store and the resync
// count, builds one result per beat and queues it in a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdr_back #(
	parameter int FRAME_BYTES = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      own_slot,
	input  wire logic [2:0]      capacity,
	input  wire logic            item_valid,
	input  wire bpdr_pkg::item_t item,
	output logic                 take,
	input  wire logic            pop,
	output logic                 empty,
	output bpdr_pkg::result_t    res
);
	import bpdr_pkg::*;

	localparam logic [3:0] FB = FRAME_BYTES[3:0];

	logic [2:0]  needed_q;
	logic [2:0]  held_q;
	logic [31:0] counter_q;
	logic [7:0]  store_q [FRAME_BYTES];

	logic [2:0]  needed_n;
	logic [2:0]  held_n;
	logic [31:0] counter_n;
	logic [7:0]  merged [FRAME_BYTES];
	logic [7:0]  store_n [FRAME_BYTES];
	logic        store_we;
	logic [2:0]  held_base;
	logic [2:0]  held_inc;
	logic [2:0]  needed_e;
	result_t     res_n;

	result_t     oslot_q [2];
	logic        owr_q;
	logic        ord_q;
	logic [1:0]  ocount_q;
	logic        opop;

	assign opop  = pop && !empty;
	assign empty = (ocount_q == 2'd0);
	assign res   = oslot_q[ord_q];
	assign take  = item_valid && ((ocount_q != 2'd2) || opop);

	always_comb begin
		res_n     = '0;
		needed_n  = needed_q;
		held_n    = held_q;
		counter_n = counter_q;
		store_we  = 1'b0;
		held_base = held_q;
		needed_e  = needed_q;
		if (needed_q == 3'd0) begin
			held_base = 3'd0;
			needed_e  = (item.kind == KIND_START_LONG) ? LEN_LONG : LEN_SHORT;
		end
		held_inc = held_base + 3'd1;
		for (int k = 0; k < FRAME_BYTES; k++) begin
			merged[k] = ({1'b0, held_base} < FB && held_base == 3'(k)) ?
				item.data : store_q[k];
		end
		store_n = merged;

		if (item.kind == KIND_COUNT_READ) begin
			res_n.status = STATUS_COUNT;
			res_n.total  = counter_q;
			counter_n    = '0;
		end else if (needed_q != 3'd0 || item.kind != KIND_PLAIN) begin
			store_we = 1'b1;
			held_n   = held_inc;
			needed_n = needed_e;
			if (needed_e == LEN_SHORT && held_inc == LEN_SHORT &&
			    merged[0] == START_DELTA && merged[1] == START_DELTA &&
			    merged[3] < SLOT_LIMIT) begin
				// grow to the extended form and keep collecting
				needed_n = LEN_EXTENDED;
			end else if (held_inc >= needed_e) begin
				if (needed_e == LEN_SHORT && merged[0] == START_DELTA &&
				    merged[1] != own_slot && merged[2] != own_slot) begin
					// not ours: drop the first byte and look again
					for (int k = 0; k < FRAME_BYTES - 1; k++) begin
						if (4'(k + 1) < {1'b0, held_inc}) begin
							store_n[k] = merged[k + 1];
						end
					end
					held_n    = held_inc - 3'd1;
					counter_n = counter_q + 32'd1;
				end else begin
					res_n.status = STATUS_FRAME;
					if (needed_e <= capacity) begin
						res_n.length = needed_e;
						for (int k = 0; k < OUT_BYTES; k++) begin
							if (3'(k) < needed_e) begin
								res_n.bytes[k] = merged[k];
							end
						end
					end
					needed_n = 3'd0;
					held_n   = 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q  <= 3'd0;
			held_q    <= 3'd0;
			counter_q <= '0;
			owr_q     <= 1'b0;
			ord_q     <= 1'b0;
			ocount_q  <= 2'd0;
		end else begin
			if (take) begin
				needed_q  <= needed_n;
				held_q    <= held_n;
				counter_q <= counter_n;
				owr_q     <= ~owr_q;
			end
			if (opop) begin
				ord_q <= ~ord_q;
			end
			if (take && !opop) begin
				ocount_q <= ocount_q + 2'd1;
			end else if (opop && !take) begin
				ocount_q <= ocount_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && store_we) begin
			store_q <= store_n;
		end
		if (take) begin
			oslot_q[owr_q] <= res_n;
		end
	end

endmodule

`default_nettype wire

// ----- tb/bpdr_deframe_check.sv -----
// ----------------------------------------------------------------------------
// bpdr_deframe_check
// Watches the request, result and config channels of the deframer, predicts
// the result of every accepted request and compares it with the result that
// is popped. Reports the failure count and the number of results still due.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdr_deframe_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic        req_type,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [1:0]  status,
	input  wire logic [2:0]  frame_length,
	input  wire logic [7:0]  frame_byte0,
	input  wire logic [7:0]  frame_byte1,
	input  wire logic [7:0]  frame_byte2,
	input  wire logic [7:0]  frame_byte3,
	input  wire logic [7:0]  frame_byte4,
	input  wire logic [7:0]  frame_byte5,
	input  wire logic [31:0] resync_total,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	output int               mismatches,
	output int               pending
);

	timeunit 1ns;
	timeprecision 1ps;

	import bpdr_pkg::*;

	localparam int   REPORT_MAX = 10;

	// predictor state
	logic [2:0]  frame_len;
	logic [2:0]  fill;
	logic [7:0]  frame_buf [0:OUT_BYTES-1];
	logic [31:0] resyncs_seen;
	logic [7:0]  slot_cfg;
	logic [2:0]  cap_cfg;

	result_t results_due [$];
	result_t want;
	result_t got;
	int      fail_total;

	function automatic result_t deframe_step(input logic kind, input logic [7:0] b);
		result_t r;
		int      k;
		r = '0;
		if (kind == REQ_COUNT) begin
			r.status = STATUS_COUNT;
			r.total = resyncs_seen;
			resyncs_seen = '0;
			return r;
		end
		if (frame_len == 3'd0) begin
			if (b == START_DELTA || b == START_BRICK)
				frame_len = LEN_SHORT;
			else if (b == START_RESPAWN)
				frame_len = LEN_LONG;
			else
				return r;
			fill = 3'd0;
		end
		if (fill < OUT_BYTES)
			frame_buf[fill] = b;
		fill = fill + 3'd1;
		// 0x41 0x41 frame with a small player number grows by one byte
		if (frame_len == LEN_SHORT && fill == 3'd4 && frame_buf[0] == START_DELTA &&
				frame_buf[1] == START_DELTA && frame_buf[3] < SLOT_LIMIT) begin
			frame_len = LEN_EXTENDED;
			return r;
		end
		if (fill >= frame_len) begin
			// frame for another slot: drop the first byte and keep collecting
			if (frame_len == LEN_SHORT && frame_buf[0] == START_DELTA &&
					frame_buf[1] != slot_cfg && frame_buf[2] != slot_cfg) begin
				for (k = 0; k + 1 < fill && k + 1 < OUT_BYTES; k++)
					frame_buf[k] = frame_buf[k + 1];
				fill = fill - 3'd1;
				resyncs_seen = resyncs_seen + 32'd1;
				return r;
			end
			r.status = STATUS_FRAME;
			if (frame_len <= cap_cfg) begin
				r.length = frame_len;
				for (k = 0; k < frame_len; k++)
					r.bytes[k] = frame_buf[k];
			end
			frame_len = 3'd0;
			fill = 3'd0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len = 3'd0;
			fill = 3'd0;
			for (int k = 0; k < OUT_BYTES; k++)
				frame_buf[k] = 8'd0;
			resyncs_seen = '0;
			slot_cfg = 8'd0;
			cap_cfg = 3'd6;
			results_due.delete();
			fail_total = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_OWN_SLOT)
					slot_cfg = cfg_data;
				else
					cap_cfg = cfg_data[2:0];
			end
			// compare before predicting: a result never belongs to the beat taken now
			if (pop && !empty) begin
				got = {status, frame_length, frame_byte5, frame_byte4, frame_byte3,
					frame_byte2, frame_byte1, frame_byte0, resync_total};
				if (results_due.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_MAX)
						$display("%0t: result beat with nothing due: %s %0d %0d %h %h",
							$realtime, "status/len/bytes/total", got.status,
							got.length, got.bytes, got.total);
				end else begin
					want = results_due.pop_front();
					if (want.status !== got.status || want.length !== got.length ||
							want.bytes !== got.bytes || want.total !== got.total) begin
						fail_total++;
						if (fail_total <= REPORT_MAX) begin
							$display("%0t: mismatch: expected status %0d len %0d",
								$realtime, want.status, want.length);
							$display("    expected bytes %h total %h",
								want.bytes, want.total);
							$display("    got status %0d len %0d bytes %h total %h",
								got.status, got.length, got.bytes, got.total);
						end
					end
				end
			end
			if (push && !full)
				results_due.push_back(deframe_step(req_type, rx_byte));
			pending <= results_due.size();
			mismatches <= fail_total;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb_byte_packet_deframer_resync.sv -----
// ----------------------------------------------------------------------------
// tb_byte_packet_deframer_resync
// Drives the deframer with directed frames and then random byte streams of
// mostly well-formed frames under several slot and capacity settings, with
// random stalls on both sides. The checker predicts and compares every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_byte_packet_deframer_resync;

	timeunit 1ns;
	timeprecision 1ps;

	import bpdr_pkg::*;

	localparam time CLK_PERIOD     = 10ns;
	localparam int  WATCHDOG_LIMIT = 2000;
	localparam int  PHASE_ITEMS    = 90;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        req_type;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [2:0]  frame_length;
	logic [7:0]  frame_byte0;
	logic [7:0]  frame_byte1;
	logic [7:0]  frame_byte2;
	logic [7:0]  frame_byte3;
	logic [7:0]  frame_byte4;
	logic [7:0]  frame_byte5;
	logic [31:0] resync_total;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	int          mismatches;
	int          pending;
	int          items_sent;
	int          quiet_cycles = 0;
	bit          send_idle;
	bit          recv_idle;
	logic [7:0]  slot_now;

	byte_packet_deframer_resync dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.frame_length (frame_length),
		.frame_byte0  (frame_byte0),
		.frame_byte1  (frame_byte1),
		.frame_byte2  (frame_byte2),
		.frame_byte3  (frame_byte3),
		.frame_byte4  (frame_byte4),
		.frame_byte5  (frame_byte5),
		.resync_total (resync_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bpdr_deframe_check u_deframe_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.frame_length (frame_length),
		.frame_byte0  (frame_byte0),
		.frame_byte1  (frame_byte1),
		.frame_byte2  (frame_byte2),
		.frame_byte3  (frame_byte3),
		.frame_byte4  (frame_byte4),
		.frame_byte5  (frame_byte5),
		.resync_total (resync_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// one beat on the request channel, with an optional gap ahead of it
	task automatic send_item(input logic kind, input logic [7:0] b);
		if (send_idle && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= kind;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	// send n bytes of seq, most significant first
	task automatic send_run(input logic [47:0] seq, input int n);
		for (int i = n - 1; i >= 0; i--)
			send_item(REQ_BYTE, seq[i*8 +: 8]);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// allow the two-stage pipeline to settle
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_OWN_SLOT)
			slot_now = val;
	endtask

	// bias towards bytes that steer the framing decisions
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return slot_now;
			1: return START_DELTA;
			2: return START_BRICK;
			3: return START_RESPAWN;
			4: return 8'($urandom_range(0, 4));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_random_unit();
		int n;
		n = 0;
		case ($urandom_range(0, 9))
			0: send_item(REQ_COUNT, 8'($urandom));
			1: send_item(REQ_BYTE, 8'($urandom));
			2: begin
				send_item(REQ_BYTE, START_BRICK);
				repeat (3) send_item(REQ_BYTE, 8'($urandom));
			end
			3: begin
				send_item(REQ_BYTE, START_RESPAWN);
				repeat (5) send_item(REQ_BYTE, 8'($urandom));
			end
			4: begin
				send_item(REQ_BYTE, START_DELTA);
				send_item(REQ_BYTE, START_DELTA);
				send_item(REQ_BYTE, pick_byte());
				send_item(REQ_BYTE, 8'($urandom_range(0, 4)));
				send_item(REQ_BYTE, pick_byte());
			end
			5: repeat (4) send_item(REQ_BYTE, pick_byte());
			default: begin
				// 0x41 frames: own-slot hits, resync chains and extensions
				send_item(REQ_BYTE, START_DELTA);
				n = $urandom_range(3, 5);
				repeat (n) send_item(REQ_BYTE, pick_byte());
			end
		endcase
	endtask

	initial begin : drive_pop
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0)
				stall--;
			else if (recv_idle && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				stall = $urandom_range(1, 13) - 1;
			end else
				pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		int         target;
		logic [4:0] pad;
		logic [2:0] cap;
		logic [7:0] slot;
		arst_n = 1'b0;
		push = 1'b0;
		req_type = REQ_BYTE;
		rx_byte = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_OWN_SLOT;
		cfg_data = 8'd0;
		items_sent = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		slot_now = 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: own slot 0, capacity 6
		send_item(REQ_BYTE, 8'h00);
		send_item(REQ_COUNT, 8'hFF);
		send_run(48'h51_12_34_56, 4);
		send_run(48'h52_FF_00_AA_55_01, 6);
		send_run(48'h41_41_05_02_07, 5);
		// other slot: shift, then the shifted bytes complete a plain frame
		send_run(48'h41_02_03_09, 4);
		send_item(REQ_BYTE, 8'h00);
		// fourth byte at the player limit: no extension, third byte is own slot
		send_run(48'h41_41_00_04, 4);
		send_item(REQ_COUNT, 8'h00);

		// over capacity
		wait_drained();
		write_reg(CFG_CAPACITY, {5'b10101, 3'd3});
		send_run(48'h52_01_02_03_04_05, 6);
		send_run(48'h51_80_7F_FF, 4);
		send_item(REQ_COUNT, 8'hAA);

		for (int phase = 0; phase < 5; phase++) begin
			wait_drained();
			case (phase)
				0: begin slot = 8'hFF; cap = 3'd7; end
				1: begin slot = START_DELTA; cap = 3'd0; end
				2: begin slot = 8'($urandom); cap = LEN_EXTENDED; end
				3: begin slot = 8'h00; cap = LEN_SHORT; end
				default: begin slot = 8'($urandom); cap = LEN_LONG; end
			endcase
			pad = 5'($urandom);
			write_reg(CFG_OWN_SLOT, slot);
			write_reg(CFG_CAPACITY, {pad, cap});
			send_idle = (phase == 0 || phase == 1 || phase == 3);
			recv_idle = (phase == 0 || phase == 2 || phase == 3);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				send_random_unit();
				// in phase 2, when pad bit 0 is set, hold off once mid-phase until every result is out
				if (phase == 2 && items_sent >= target - PHASE_ITEMS / 2 && pad[0]) begin
					wait_drained();
					pad[0] = 1'b0;
				end
			end
		end

		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
